// ===== hdl/rzwh_pkg.sv =====
// rzwh_pkg: shared types and constants of the range zone window histogram
// no dependencies; imported by every module of the block

package rzwh_pkg;

	localparam int NUM_ZONES = 3;
	localparam int DIST_W    = 16;
	localparam int THR_W     = 16;
	localparam int BIN_W     = 5;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ZONE_NEAR = 2'd0,
		REG_ZONE_MID  = 2'd1,
		REG_ZONE_FAR  = 2'd2
	} reg_idx_t;

	localparam logic [THR_W-1:0] THR_NEAR_RST = 16'd300;
	localparam logic [THR_W-1:0] THR_MID_RST  = 16'd1200;
	localparam logic [THR_W-1:0] THR_FAR_RST  = 16'd1500;

	typedef struct packed {
		logic adv;
		logic ev;
	} zone_ctl_t;

endpackage

// ===== hdl/rzwh_zone.sv =====
// rzwh_zone: event window and running count of one zone
// depends on rzwh_pkg

module rzwh_zone #(
	parameter int WINDOW_LEN = 16,
	parameter int CNT_W      = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rzwh_pkg::zone_ctl_t ctl,
	output logic [CNT_W-1:0]   count_nxt
);
	import rzwh_pkg::*;

	logic [WINDOW_LEN-1:0] win_q;
	logic [CNT_W-1:0]      count_q;
	logic                  leaving;

	assign leaving = win_q[WINDOW_LEN-1];

	always_comb begin
		count_nxt = count_q;
		if (ctl.ev && !leaving) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (!ctl.ev && leaving) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
		end else if (ctl.adv) begin
			win_q   <= {win_q[WINDOW_LEN-2:0], ctl.ev};
			count_q <= count_nxt;
		end
	end

	// running count tracks the window contents
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(win_q)))
		else $error("zone count out of step with window");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_LEN))
		else $error("zone count above window length");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.adv |=> $stable(win_q) && $stable(count_q))
		else $error("zone window moved without a request");

endmodule

// ===== hdl/rzwh_out.sv =====
// rzwh_out: histogram bins from the updated zone counts, and the result register
// depends on rzwh_pkg

module rzwh_out #(
	parameter int WINDOW_LEN = 16,
	parameter int CNT_W      = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               take,
	input  logic [rzwh_pkg::NUM_ZONES-1:0][CNT_W-1:0] counts,
	output logic                               adv,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rzwh_pkg::BIN_W-1:0]         bin_near,
	output logic [rzwh_pkg::BIN_W-1:0]         bin_mid,
	output logic [rzwh_pkg::BIN_W-1:0]         bin_far,
	output logic [rzwh_pkg::BIN_W-1:0]         bin_beyond,
	output logic                               order_fault
);
	import rzwh_pkg::*;

	localparam int EXT_W = CNT_W + BIN_W;

	logic [NUM_ZONES-1:0][BIN_W-1:0] diff;
	logic [NUM_ZONES-1:0]            neg;
	logic [EXT_W-1:0]                beyond_ext;
	logic [EXT_W-1:0]                near_ext;
	logic                            valid_q;
	logic [BIN_W-1:0]                near_q, mid_q, far_q, beyond_q;
	logic                            fault_q;
	logic [EXT_W-1:0]                d_ext;

	always_comb begin
		diff = '0;
		neg  = '0;
		for (int z = 1; z < NUM_ZONES; z++) begin
			d_ext = EXT_W'(counts[z]) - EXT_W'(counts[z-1]);
			if (counts[z] >= counts[z-1]) begin
				diff[z] = d_ext[BIN_W-1:0];
			end else begin
				neg[z] = 1'b1;
			end
		end
	end

	assign near_ext   = EXT_W'(counts[0]);
	assign beyond_ext = EXT_W'(WINDOW_LEN) - EXT_W'(counts[NUM_ZONES-1]);

	assign adv = take && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_q   <= near_ext[BIN_W-1:0];
			mid_q    <= diff[1];
			far_q    <= diff[2];
			beyond_q <= beyond_ext[BIN_W-1:0];
			fault_q  <= |neg;
		end
	end

	assign out_valid   = valid_q;
	assign bin_near    = near_q;
	assign bin_mid     = mid_q;
	assign bin_far     = far_q;
	assign bin_beyond  = beyond_q;
	assign order_fault = fault_q;

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !adv)
		else $error("result overwritten while stalled");

	a_fault_bins: assert property (@(posedge clk) disable iff (!arst_n)
		adv && neg[1] |=> bin_mid == '0 && order_fault)
		else $error("negative difference not floored");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("loaded result not shown");

endmodule

// ===== hdl/range_zone_window_histogram.sv =====
// range_zone_window_histogram: sliding window zone histogram of downward range
// depends on rzwh_pkg, rzwh_zone, rzwh_out
//
// usage
//   each request on the input channel (in_valid/in_ready) carries one range
//   sample: distance_mm and sample_valid. it passes an input register, then
//   three threshold compares update the zone windows and counts, and the
//   four bins and order_fault are loaded into the result register, shown on
//   the output channel (out_valid/out_ready)
//   throughput: one request per cycle while out_ready is held high, set by
//   the single compare and count update stage between the input and result
//   registers
//   receiver stall: the result register holds; the input register keeps one
//   more request, after which in_ready drops until the result is taken
//   thresholds are written through wr_en/wr_index/wr_data while idle; a write
//   leaves windows and counts as they are; an index past the list is ignored
//   reset: windows and counts clear, thresholds go to 300, 1200 and 1500 mm,
//   both channels empty

module range_zone_window_histogram #(
	parameter int WINDOW_LEN = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rzwh_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [rzwh_pkg::THR_W-1:0]     wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rzwh_pkg::DIST_W-1:0]    distance_mm,
	input  logic                           sample_valid,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rzwh_pkg::BIN_W-1:0]     bin_near,
	output logic [rzwh_pkg::BIN_W-1:0]     bin_mid,
	output logic [rzwh_pkg::BIN_W-1:0]     bin_far,
	output logic [rzwh_pkg::BIN_W-1:0]     bin_beyond,
	output logic                           order_fault
);
	import rzwh_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_LEN + 1);

	logic [NUM_ZONES-1:0][THR_W-1:0] thr_q;
	logic                            valid_s1;
	logic [DIST_W-1:0]               dist_s1;
	logic                            smp_s1;
	logic                            adv;
	logic [NUM_ZONES-1:0][CNT_W-1:0] counts;
	zone_ctl_t                       zctl [NUM_ZONES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[REG_ZONE_NEAR] <= THR_NEAR_RST;
			thr_q[REG_ZONE_MID]  <= THR_MID_RST;
			thr_q[REG_ZONE_FAR]  <= THR_FAR_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ZONE_NEAR: thr_q[REG_ZONE_NEAR] <= wr_data;
				REG_ZONE_MID:  thr_q[REG_ZONE_MID]  <= wr_data;
				REG_ZONE_FAR:  thr_q[REG_ZONE_FAR]  <= wr_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dist_s1 <= distance_mm;
			smp_s1  <= sample_valid;
		end
	end

	for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
		assign zctl[z].adv = adv;
		assign zctl[z].ev  = smp_s1 && (dist_s1 < thr_q[z]);

		rzwh_zone #(
			.WINDOW_LEN(WINDOW_LEN),
			.CNT_W     (CNT_W)
		) u_zone (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (zctl[z]),
			.count_nxt(counts[z])
		);
	end

	rzwh_out #(
		.WINDOW_LEN(WINDOW_LEN),
		.CNT_W     (CNT_W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (valid_s1),
		.counts     (counts),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_near   (bin_near),
		.bin_mid    (bin_mid),
		.bin_far    (bin_far),
		.bin_beyond (bin_beyond),
		.order_fault(order_fault)
	);

endmodule

// ===== test/testbench.sv =====
// testbench: directed and random check of range_zone_window_histogram against
// an in-bench zone window predictor held in a small scoreboard class
// depends on rzwh_pkg and the block's rtl

module testbench;
	import rzwh_pkg::*;

	localparam int WIN_LEN = 16;
	localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [BIN_W-1:0] bin_near;
		logic [BIN_W-1:0] bin_mid;
		logic [BIN_W-1:0] bin_far;
		logic [BIN_W-1:0] bin_beyond;
		logic             order_fault;
	} zone_hist_t;

	class zone_hist_scoreboard;
		logic [THR_W-1:0]   zone_thr [NUM_ZONES];
		logic [WIN_LEN-1:0] zone_win [NUM_ZONES];
		logic [BIN_W-1:0]   zone_cnt [NUM_ZONES];
		zone_hist_t         histograms_due [$];
		int unsigned        mismatches;
		int unsigned        results_seen;

		function new();
			zone_thr[0] = THR_NEAR_RST;
			zone_thr[1] = THR_MID_RST;
			zone_thr[2] = THR_FAR_RST;
			for (int z = 0; z < NUM_ZONES; z++) begin
				zone_win[z] = '0;
				zone_cnt[z] = '0;
			end
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_threshold(logic [REG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
			if (idx < NUM_ZONES) begin
				zone_thr[idx] = val;
			end
		endfunction

		function int unsigned pending();
			return histograms_due.size();
		endfunction

		function void record_sample(logic [DIST_W-1:0] range_mm, logic valid);
			zone_hist_t want;
			logic       ev;
			for (int z = 0; z < NUM_ZONES; z++) begin
				ev = valid && (range_mm < zone_thr[z]);
				if (ev && !zone_win[z][WIN_LEN-1]) begin
					zone_cnt[z] = zone_cnt[z] + 1'b1;
				end else if (!ev && zone_win[z][WIN_LEN-1]) begin
					zone_cnt[z] = zone_cnt[z] - 1'b1;
				end
				zone_win[z] = {zone_win[z][WIN_LEN-2:0], ev};
			end
			want.bin_near = zone_cnt[0];
			want.order_fault = 1'b0;
			if (zone_cnt[1] >= zone_cnt[0]) begin
				want.bin_mid = zone_cnt[1] - zone_cnt[0];
			end else begin
				want.bin_mid = '0;
				want.order_fault = 1'b1;
			end
			if (zone_cnt[2] >= zone_cnt[1]) begin
				want.bin_far = zone_cnt[2] - zone_cnt[1];
			end else begin
				want.bin_far = '0;
				want.order_fault = 1'b1;
			end
			want.bin_beyond = BIN_W'(WIN_LEN) - zone_cnt[2];
			histograms_due.push_back(want);
		endfunction

		function void check_histogram(zone_hist_t got);
			zone_hist_t want;
			results_seen++;
			if (histograms_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: none outstanding, got %0d %0d %0d %0d %0b",
						results_seen, got.bin_near, got.bin_mid, got.bin_far,
						got.bin_beyond, got.order_fault);
				end
				return;
			end
			want = histograms_due.pop_front();
			if (got.bin_near !== want.bin_near || got.bin_mid !== want.bin_mid ||
				got.bin_far !== want.bin_far || got.bin_beyond !== want.bin_beyond ||
				got.order_fault !== want.order_fault) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: expected %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
						results_seen, want.bin_near, want.bin_mid, want.bin_far,
						want.bin_beyond, want.order_fault, got.bin_near, got.bin_mid,
						got.bin_far, got.bin_beyond, got.order_fault);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [THR_W-1:0]     wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [DIST_W-1:0]    distance_mm;
	logic                 sample_valid;
	logic                 out_valid;
	logic                 out_ready;
	logic [BIN_W-1:0]     bin_near;
	logic [BIN_W-1:0]     bin_mid;
	logic [BIN_W-1:0]     bin_far;
	logic [BIN_W-1:0]     bin_beyond;
	logic                 order_fault;

	zone_hist_scoreboard sb;
	int unsigned         send_gap_pct;
	int unsigned         recv_gap_pct;
	bit                  hold_req;

	range_zone_window_histogram i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DIST_W-1:0] clamp_dist(int x);
		if (x < 0) begin
			return '0;
		end else if (x > 65535) begin
			return '1;
		end
		return DIST_W'(x);
	endfunction

	function automatic logic [DIST_W-1:0] pick_centre();
		logic [THR_W-1:0] t;
		t = sb.zone_thr[$urandom_range(NUM_ZONES-1)];
		case ($urandom_range(4))
			0: return DIST_W'($urandom);
			1: return clamp_dist(int'(t) + int'($urandom_range(4)) - 2);
			2: return $urandom_range(1) ? '1 : '0;
			default: return (t == 0) ? '0 : DIST_W'($urandom_range(int'(t) - 1));
		endcase
	endfunction

	task automatic push_sample(input logic [DIST_W-1:0] range_mm, input logic valid);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance_mm <= range_mm;
		sample_valid <= valid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.record_sample(range_mm, valid);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_threshold(idx, val);
	endtask

	task automatic set_zones(input logic [THR_W-1:0] n, m, f);
		write_reg(REG_ZONE_NEAR, n);
		write_reg(REG_ZONE_MID, m);
		write_reg(REG_ZONE_FAR, f);
		wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned       sent;
		int unsigned       run_len;
		int unsigned       valid_pct;
		logic [DIST_W-1:0] centre;
		bit                noise;
		sent = 0;
		while (sent < count) begin
			run_len = $urandom_range(24, 1);
			noise = ($urandom_range(9) < 2);
			centre = pick_centre();
			valid_pct = ($urandom_range(3) == 0) ? 50 : 95;
			for (int i = 0; i < run_len && sent < count; i++) begin
				if (noise) begin
					push_sample(DIST_W'($urandom), 1'($urandom));
				end else begin
					push_sample(clamp_dist(int'(centre) + int'($urandom_range(6)) - 3),
						$urandom_range(99) < valid_pct);
				end
				sent++;
			end
		end
	endtask

	// result side: random stalls plus one long hold-off to back up the input
	initial begin
		int unsigned hold_left;
		zone_hist_t  got;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {bin_near, bin_mid, bin_far, bin_beyond, order_fault};
				sb.check_histogram(got);
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	initial begin
		logic [THR_W-1:0] a, b, c;
		sb = new();
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_ZONE_NEAR;
		wr_data <= '0;
		in_valid <= 1'b0;
		distance_mm <= '0;
		sample_valid <= 1'b0;
		hold_req = 1'b0;
		send_gap_pct = 9;
		recv_gap_pct = 64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: edges of each zone, invalid sample, then twelve valid samples at 0 mm
		push_sample(16'd0, 1'b1);
		push_sample(16'd299, 1'b1);
		push_sample(16'd300, 1'b1);
		push_sample(16'd1199, 1'b1);
		push_sample(16'd1200, 1'b1);
		push_sample(16'd1499, 1'b1);
		push_sample(16'd1500, 1'b1);
		push_sample(16'hFFFF, 1'b1);
		push_sample(16'd0, 1'b0);
		repeat (12) push_sample(16'd0, 1'b1);
		wait_idle();

		// unused index, then reversed thresholds without clearing the windows
		write_reg(REG_NONE, '1);
		set_zones(16'd1500, 16'd1200, 16'd300);
		push_sample(16'd1300, 1'b1);
		push_sample(16'd0, 1'b1);
		push_sample(16'd250, 1'b1);
		push_sample(16'd1250, 1'b0);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					a = THR_W'($urandom_range(20000));
					b = a + THR_W'($urandom_range(20000));
					c = b + THR_W'($urandom_range(25000));
				end
				1: begin
					a = '0;
					b = '0;
					c = '0;
				end
				2: begin
					a = '1;
					b = '1;
					c = '1;
				end
				3: begin
					a = THR_W'($urandom);
					b = THR_W'($urandom);
					c = THR_W'($urandom);
				end
				4: begin
					a = 16'd1500;
					b = 16'd1200;
					c = 16'd300;
				end
				5: begin
					a = THR_W'($urandom_range(600));
					b = a + THR_W'($urandom_range(600));
					c = b + THR_W'($urandom_range(600));
				end
				6: begin
					a = 16'd100;
					b = '1;
					c = '0;
				end
				default: begin
					a = THR_NEAR_RST;
					b = THR_MID_RST;
					c = THR_FAR_RST;
				end
			endcase
			set_zones(a, b, c);
			if (p < 3) begin
				send_gap_pct = 9;
				recv_gap_pct = 64;
			end else if (p < 6) begin
				send_gap_pct = 64;
				recv_gap_pct = 9;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			if (p == 0) begin
				hold_req = 1'b1;
			end
			run_random(PHASE_ITEMS);
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("range_zone_window_histogram: match");
		end else begin
			$display("range_zone_window_histogram: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("range_zone_window_histogram: mismatch");
		$finish;
	end

endmodule
